// File: design/lpim_pkg.sv
// Shared constants and types for the LED panel pixel index map.
// No dependencies; imported by the top level and its checker.
package lpim_pkg;

  localparam int PANEL_SIDE  = 16;
  localparam int SCREEN_SIDE = 32;
  localparam int PANEL_COUNT = 4;

  localparam int COORD_W = 8;
  localparam int IDX_W   = 10;
  localparam int LOCAL_W = $clog2(PANEL_SIDE);
  localparam int PANEL_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH      = 3'd0,
    REG_GRID_HEIGHT     = 3'd1,
    REG_START_CORNER    = 3'd2,
    REG_LAYOUT_VERTICAL = 3'd3,
    REG_GRID_ZIGZAG     = 3'd4,
    REG_ORDER_TABLE     = 3'd5,
    REG_ROTATION_CODES  = 3'd6,
    REG_ROW_ZIGZAG_MASK = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_code_t;

endpackage

// File: design/led_panel_pixel_index_map_unit.sv
// Beats pass the input stage, then the result stage, to the out_valid strobe.
// Throughput: one pixel per cycle; busy stays low and results cannot be stalled.
// cfg_ready is always high; a write applies to any pixel in the input stage once it lands.
// Reset (rst_n low, synchronous) clears the pipeline valids and loads the
// register defaults: 2x2 grid, top-left start, row chaining, identity order.
module led_panel_pixel_index_map_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lpim_pkg::COORD_W-1:0]      in_pixel_x,
  input  logic [lpim_pkg::COORD_W-1:0]      in_pixel_y,
  output logic                              out_valid,
  output logic [lpim_pkg::IDX_W-1:0]        out_strip_index,
  output logic                              out_in_range,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpim_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lpim_pkg::*;

  localparam logic [LOCAL_W-1:0] LOCAL_MAX = LOCAL_W'(PANEL_SIDE - 1);

  // configuration registers
  logic [2:0] grid_width_r, grid_height_r;
  logic [1:0] start_corner_r;
  logic       layout_vertical_r, grid_zigzag_r;
  logic [7:0] order_table_r, rotation_codes_r;
  logic [3:0] row_zigzag_mask_r;

  // input stage
  logic               in_valid_r;
  logic [COORD_W-1:0] pixel_x_r, pixel_y_r;

  // result stage
  logic             out_valid_r;
  logic [IDX_W-1:0] strip_index_r, strip_index_nxt;
  logic             in_range_r, in_range_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r      <= 3'd2;
      grid_height_r     <= 3'd2;
      start_corner_r    <= 2'd0;
      layout_vertical_r <= 1'b0;
      grid_zigzag_r     <= 1'b0;
      order_table_r     <= 8'd228;
      rotation_codes_r  <= 8'd0;
      row_zigzag_mask_r <= 4'd15;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:      grid_width_r      <= cfg_data[2:0];
        REG_GRID_HEIGHT:     grid_height_r     <= cfg_data[2:0];
        REG_START_CORNER:    start_corner_r    <= cfg_data[1:0];
        REG_LAYOUT_VERTICAL: layout_vertical_r <= cfg_data[0];
        REG_GRID_ZIGZAG:     grid_zigzag_r     <= cfg_data[0];
        REG_ORDER_TABLE:     order_table_r     <= cfg_data;
        REG_ROTATION_CODES:  rotation_codes_r  <= cfg_data;
        REG_ROW_ZIGZAG_MASK: row_zigzag_mask_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pixel_x_r <= in_pixel_x;
      pixel_y_r <= in_pixel_y;
    end
    if (in_valid_r) begin
      strip_index_r <= strip_index_nxt;
      in_range_r    <= in_range_nxt;
    end
  end

  // panel grid: 8-bit wrapping arithmetic throughout
  logic [COORD_W-1:0] px, py, cx, cy, w8, h8, major, minor, span, minor_eff, pos;
  logic [COORD_W-1:0] prod;
  logic [PANEL_W-1:0] panel;
  logic [LOCAL_W-1:0] lx, ly, rx, ry, col;
  rot_code_t          rot;

  always_comb begin
    px = pixel_x_r >> LOCAL_W;
    py = pixel_y_r >> LOCAL_W;
    lx = pixel_x_r[LOCAL_W-1:0];
    ly = pixel_y_r[LOCAL_W-1:0];
    w8 = {5'd0, grid_width_r};
    h8 = {5'd0, grid_height_r};

    cx = start_corner_r[0] ? (w8 - 8'd1 - px) : px;
    cy = start_corner_r[1] ? (h8 - 8'd1 - py) : py;

    // row chaining walks cx within a row of cy; column chaining swaps roles
    if (layout_vertical_r) begin
      major = cx;
      minor = cy;
      span  = h8;
    end else begin
      major = cy;
      minor = cx;
      span  = w8;
    end
    minor_eff = (grid_zigzag_r && major[0]) ? (span - 8'd1 - minor) : minor;
    prod      = major * span;
    pos       = prod + minor_eff;

    if (pos < COORD_W'(PANEL_COUNT) && pos < 8'd4)
      panel = order_table_r[{pos[1:0], 1'b0} +: PANEL_W];
    else
      panel = '0;

    rot = rot_code_t'(rotation_codes_r[{panel, 1'b0} +: 2]);
    case (rot)
      ROT_90: begin
        rx = LOCAL_MAX - ly;
        ry = lx;
      end
      ROT_180: begin
        rx = LOCAL_MAX - lx;
        ry = LOCAL_MAX - ly;
      end
      ROT_270: begin
        rx = ly;
        ry = LOCAL_MAX - lx;
      end
      default: begin
        rx = lx;
        ry = ly;
      end
    endcase

    col = (row_zigzag_mask_r[panel] && ry[0]) ? (LOCAL_MAX - rx) : rx;

    in_range_nxt    = (pixel_x_r < COORD_W'(SCREEN_SIDE)) &&
                      (pixel_y_r < COORD_W'(SCREEN_SIDE));
    strip_index_nxt = in_range_nxt ? IDX_W'({panel, ry, col}) : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_strip_index = strip_index_r;
  assign out_in_range    = in_range_r;

endmodule

// File: design/lpim_checker.sv
// Port-level checks for led_panel_pixel_index_map_unit, bound to the top level.
// Depends on lpim_pkg for the screen size.
module lpim_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [lpim_pkg::COORD_W-1:0]      in_pixel_x,
  input logic [lpim_pkg::COORD_W-1:0]      in_pixel_y,
  input logic                              out_valid,
  input logic [lpim_pkg::IDX_W-1:0]        out_strip_index,
  input logic                              out_in_range
);
  import lpim_pkg::*;

  // every accepted beat yields one strobe, after the input and result stage registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("missing result strobe for accepted beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without accepted beat");

  a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in_range ==
      (($past(in_pixel_x, 2) < COORD_W'(SCREEN_SIDE)) &&
       ($past(in_pixel_y, 2) < COORD_W'(SCREEN_SIDE)))))
    else $error("in_range does not match the accepted coordinate");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_strip_index == '0))
    else $error("out of range pixel with nonzero index");

endmodule

bind led_panel_pixel_index_map_unit lpim_checker u_lpim_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_pixel_x      (in_pixel_x),
  .in_pixel_y      (in_pixel_y),
  .out_valid       (out_valid),
  .out_strip_index (out_strip_index),
  .out_in_range    (out_in_range)
);
